// ----- hdl/ctpp_pkg.sv -----
// Shared types, constants and helpers for the camera tracking packet parser.
// No dependencies; imported by every module under hdl/.
`default_nettype none

package ctpp_pkg;

	localparam int PACKET_BYTES = 29;
	localparam int COUNT_W      = 6;
	localparam int IDX_W        = $clog2(PACKET_BYTES);
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(PACKET_BYTES);
	localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(PACKET_BYTES - 1);
	localparam logic [7:0] CHECK_BASE = 8'h40;
	localparam logic [7:0] IDENT_RESET = 8'hD1;

	localparam int TDATA_W = 216;
	localparam int TUSER_W = 2;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_LENGTH   = 2'd1,
		ST_IDENT    = 2'd2,
		ST_CHECKSUM = 2'd3
	} status_t;

	// One input word as held in the input register.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} in_word_t;

	typedef struct packed {
		status_t            status;
		logic [7:0]         camera_id;
		logic signed [23:0] pan_raw;
		logic signed [23:0] tilt_raw;
		logic signed [23:0] roll_raw;
		logic signed [23:0] pos_x_raw;
		logic signed [23:0] pos_y_raw;
		logic signed [23:0] pos_z_raw;
		logic [23:0]        zoom_value;
		logic [23:0]        focus_value;
		logic [15:0]        user_value;
	} result_t;

	function automatic logic [23:0] be24(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2);
		be24 = {b0, b1, b2};
	endfunction

	// Everything but status, first field in the low bits.
	function automatic logic [TDATA_W-1:0] pack_data(input result_t r);
		pack_data = {r.user_value, r.focus_value, r.zoom_value,
			r.pos_z_raw, r.pos_y_raw, r.pos_x_raw,
			r.roll_raw, r.tilt_raw, r.pan_raw, r.camera_id};
	endfunction

endpackage

`default_nettype wire

// ----- hdl/ctpp_in_stage.sv -----
// Input register for the byte stream, with ready derived from downstream take.
// Depends on ctpp_pkg.
`default_nettype none

module ctpp_in_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_axis_tvalid,
	output logic                 s_axis_tready,
	input  wire logic [7:0]      s_axis_tdata,  // [7:0] data_byte
	input  wire logic            s_axis_tlast,  // end_of_datagram
	input  wire logic            take,
	output logic                 valid_s1,
	output ctpp_pkg::in_word_t   word_s1
);
	import ctpp_pkg::*;

	logic accept;

	assign s_axis_tready = !valid_s1 || take;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1.data_byte <= s_axis_tdata;
			word_s1.last      <= s_axis_tlast;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/ctpp_assembler.sv -----
// Byte counter, running checksum, packet store and final-byte checks.
// Depends on ctpp_pkg.
`default_nettype none

module ctpp_assembler (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wen,
	input  wire logic [7:0]         cfg_wdata,
	input  wire logic               valid_s1,
	input  wire ctpp_pkg::in_word_t word_s1,
	input  wire logic               out_free,
	output logic                    take,
	output logic                    res_load,
	output ctpp_pkg::result_t       res
);
	import ctpp_pkg::*;

	logic [7:0]         ident_q;
	logic [COUNT_W-1:0] byte_count_q;
	logic [7:0]         running_sum_q;
	logic [7:0]         store_q [PACKET_BYTES];
	logic [7:0]         expect_chk;
	status_t            status;

	// A final byte waits until the output register has room.
	assign take     = valid_s1 && (!word_s1.last || out_free);
	assign res_load = take && word_s1.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ident_q <= IDENT_RESET;
		end else if (cfg_wen) begin
			ident_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			running_sum_q <= '0;
		end else if (take) begin
			if (word_s1.last) begin
				byte_count_q  <= '0;
				running_sum_q <= '0;
			end else begin
				if (byte_count_q != COUNT_MAX) begin
					byte_count_q <= byte_count_q + COUNT_W'(1);
				end
				if (byte_count_q < COUNT_LAST) begin
					running_sum_q <= running_sum_q + word_s1.data_byte;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && (byte_count_q < COUNT_FULL)) begin
			store_q[byte_count_q[IDX_W-1:0]] <= word_s1.data_byte;
		end
	end

	// The final byte is the checksum byte itself; the sum so far covers the rest.
	assign expect_chk = CHECK_BASE - running_sum_q;

	always_comb begin
		priority if (byte_count_q != COUNT_LAST) begin
			status = ST_LENGTH;
		end else if (store_q[0] != ident_q) begin
			status = ST_IDENT;
		end else if (word_s1.data_byte != expect_chk) begin
			status = ST_CHECKSUM;
		end else begin
			status = ST_OK;
		end
	end

	always_comb begin
		res        = '0;
		res.status = status;
		if (status == ST_OK) begin
			res.camera_id   = store_q[1];
			res.pan_raw     = $signed(be24(store_q[2],  store_q[3],  store_q[4]));
			res.tilt_raw    = $signed(be24(store_q[5],  store_q[6],  store_q[7]));
			res.roll_raw    = $signed(be24(store_q[8],  store_q[9],  store_q[10]));
			res.pos_x_raw   = $signed(be24(store_q[11], store_q[12], store_q[13]));
			res.pos_y_raw   = $signed(be24(store_q[14], store_q[15], store_q[16]));
			res.pos_z_raw   = $signed(be24(store_q[17], store_q[18], store_q[19]));
			res.zoom_value  = be24(store_q[20], store_q[21], store_q[22]);
			res.focus_value = be24(store_q[23], store_q[24], store_q[25]);
			res.user_value  = {store_q[26], store_q[27]};
		end
	end

	a_clear_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (byte_count_q == '0) && (running_sum_q == '0))
		else $error("count or sum not cleared after final byte");

	a_ok_needs_length: assert property (@(posedge clk) disable iff (!arst_n)
		res_load && (res.status == ST_OK) |-> byte_count_q == COUNT_LAST)
		else $error("ok status on wrong length");

	a_fail_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_load && (res.status != ST_OK) |->
			(res.camera_id == '0) && (res.user_value == '0) && (res.pan_raw == '0))
		else $error("fields not zero on failed check");

	a_no_result_midword: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> out_free)
		else $error("result loaded into a full output register");

endmodule

`default_nettype wire

// ----- hdl/ctpp_out_reg.sv -----
// Result register driving the master-side stream.
// Depends on ctpp_pkg.
`default_nettype none

module ctpp_out_reg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            res_load,
	input  wire ctpp_pkg::result_t               res,
	output logic                                 out_free,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [ctpp_pkg::TDATA_W-1:0]         m_axis_tdata,
	output logic [ctpp_pkg::TUSER_W-1:0]         m_axis_tuser
);
	import ctpp_pkg::*;

	assign out_free = !m_axis_tvalid || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (res_load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			m_axis_tdata <= pack_data(res);
			m_axis_tuser <= res.status;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/camera_tracking_packet_parser.sv -----
// Top level of the camera tracking packet parser: input register, assembler, result register.
// Depends on ctpp_pkg, ctpp_in_stage, ctpp_assembler and ctpp_out_reg.
//
//   channel   dir  handshake              payload
//   s_axis    in   tvalid/tready          tdata[7:0] data_byte, tlast end_of_datagram
//   m_axis    out  tvalid/tready          tdata: 216 bits of fields, tuser[1:0] status
//   cfg       in   cfg_wen (no wait)      cfg_wdata[7:0] packet_identifier
//
// One byte per cycle sustained, except during the stall below. A word waits in the
// input register, then updates count/sum/store when taken; a final byte loads the result
// register in that same step, so m_axis_tvalid rises in the cycle after it is taken.
// The only stall: a final byte holds in the input register while the result register
// is full and not being drained; ready then drops until it moves on.
// Reset clears valid flags, count, sum and loads identifier 0xD1; the store is not reset.
`default_nettype none

module camera_tracking_packet_parser (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wen,
	input  wire logic [7:0]                      cfg_wdata,     // packet_identifier
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
	input  wire logic                            s_axis_tlast,  // end_of_datagram
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// tdata from bit 0: camera_id 8, pan_raw 24, tilt_raw 24, roll_raw 24,
	// pos_x_raw 24, pos_y_raw 24, pos_z_raw 24, zoom_value 24, focus_value 24,
	// user_value 16
	output logic [ctpp_pkg::TDATA_W-1:0]         m_axis_tdata,
	output logic [ctpp_pkg::TUSER_W-1:0]         m_axis_tuser   // [1:0] status
);
	import ctpp_pkg::*;

	logic     valid_s1;
	in_word_t word_s1;
	logic     take;
	logic     res_load;
	logic     out_free;
	result_t  res;

	ctpp_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.take          (take),
		.valid_s1      (valid_s1),
		.word_s1       (word_s1)
	);

	ctpp_assembler u_asm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.valid_s1  (valid_s1),
		.word_s1   (word_s1),
		.out_free  (out_free),
		.take      (take),
		.res_load  (res_load),
		.res       (res)
	);

	ctpp_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.res_load      (res_load),
		.res           (res),
		.out_free      (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// A held final byte must block new input words.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && word_s1.last && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input accepted behind a stalled final byte");

	// A result loads only from a taken final byte.
	a_result_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> valid_s1 && word_s1.last && take)
		else $error("result without a final byte");

endmodule

`default_nettype wire
